/* hdl/sct_pkg.sv */
// sct_pkg: shared widths, state and register codes, and the types used by
// the SIP call state tracker. No dependencies.
package sct_pkg;

    localparam int CODE_W          = 7;
    localparam int MSG_W           = 10;
    localparam int SEQ_W           = 32;
    localparam int STATE_W         = 3;
    localparam int APB_AW          = 4;
    localparam int APB_DW          = 32;
    localparam int REG_IDX_W       = 2;
    localparam int QUEUE_DEPTH_DEF = 2;

    // dialog states
    localparam logic [STATE_W-1:0] ST_NONE      = 3'd0;
    localparam logic [STATE_W-1:0] ST_SETUP     = 3'd1;
    localparam logic [STATE_W-1:0] ST_INCALL    = 3'd2;
    localparam logic [STATE_W-1:0] ST_CANCELLED = 3'd3;
    localparam logic [STATE_W-1:0] ST_REJECTED  = 3'd4;
    localparam logic [STATE_W-1:0] ST_BUSY      = 3'd5;
    localparam logic [STATE_W-1:0] ST_DIVERTED  = 3'd6;
    localparam logic [STATE_W-1:0] ST_COMPLETED = 3'd7;

    // response codes
    localparam logic [MSG_W-1:0] RSP_TEMP_UNAVAIL    = 10'd480;
    localparam logic [MSG_W-1:0] RSP_BUSY_HERE       = 10'd486;
    localparam logic [MSG_W-1:0] RSP_DECLINE_ALL     = 10'd600;
    localparam logic [MSG_W-1:0] RSP_CLIENT_ERR_BASE = 10'd400;
    localparam logic [MSG_W-1:0] RSP_REDIRECT_BASE   = 10'd300;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_INVITE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACK    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CANCEL = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_BYE    = 2'd3;

    localparam logic [CODE_W-1:0] INVITE_CODE_RST = 7'd1;
    localparam logic [CODE_W-1:0] ACK_CODE_RST    = 7'd2;
    localparam logic [CODE_W-1:0] CANCEL_CODE_RST = 7'd3;
    localparam logic [CODE_W-1:0] BYE_CODE_RST    = 7'd4;

    typedef struct packed {
        logic [CODE_W-1:0] invite_code;
        logic [CODE_W-1:0] ack_code;
        logic [CODE_W-1:0] cancel_code;
        logic [CODE_W-1:0] bye_code;
    } cfg_t;

    typedef struct packed {
        logic invite;
        logic ack;
        logic cancel;
        logic bye;
        logic busy;
        logic above_400;
        logic above_300;
    } msg_class_t;

    typedef struct packed {
        logic              new_call;
        msg_class_t        cls;
        logic [SEQ_W-1:0]  seq_number;
    } queue_entry_t;

endpackage

/* hdl/sct_ifs.sv */
// sct_ifs: valid/ready channel interfaces for message beats in and
// result beats out. Depends on sct_pkg.
interface sct_msg_if import sct_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             new_call;
    logic [MSG_W-1:0] msg_code;
    logic [SEQ_W-1:0] seq_number;

    modport source (output valid, new_call, msg_code, seq_number, input ready);
    modport sink   (input valid, new_call, msg_code, seq_number, output ready);
endinterface

interface sct_res_if import sct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] call_phase;
    logic               tracked;
    logic               call_started;
    logic               call_ended;

    modport source (output valid, call_phase, tracked, call_started, call_ended,
                    input ready);
    modport sink   (input valid, call_phase, tracked, call_started, call_ended,
                    output ready);
endinterface

/* hdl/sip_call_state_tracker.sv */
// SIP call state tracker: one result beat per message beat.
// A message accepted into the queue is popped by the back part, which registers its result.
// Throughput: one message per cycle unless res_out stalls; the state update is a combinational
// compare-and-select in the back part, and a short queue decouples it from the front.
// Reset (rst_n, async, active low): untracked, state none, CSeq zero, method
// codes INVITE 1, ACK 2, CANCEL 3, BYE 4, queue and output register empty.
module sip_call_state_tracker import sct_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    sct_msg_if.sink           msg_in,
    sct_res_if.source         res_out
);

    cfg_t                 cfg_reg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    logic                 push, pop, full, empty;
    queue_entry_t         push_data, pop_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.invite_code <= INVITE_CODE_RST;
            cfg_reg.ack_code    <= ACK_CODE_RST;
            cfg_reg.cancel_code <= CANCEL_CODE_RST;
            cfg_reg.bye_code    <= BYE_CODE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_INVITE: cfg_reg.invite_code <= pwdata[CODE_W-1:0];
                REG_ACK:    cfg_reg.ack_code    <= pwdata[CODE_W-1:0];
                REG_CANCEL: cfg_reg.cancel_code <= pwdata[CODE_W-1:0];
                REG_BYE:    cfg_reg.bye_code    <= pwdata[CODE_W-1:0];
                default:    cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_INVITE: prdata = {{(APB_DW-CODE_W){1'b0}}, cfg_reg.invite_code};
            REG_ACK:    prdata = {{(APB_DW-CODE_W){1'b0}}, cfg_reg.ack_code};
            REG_CANCEL: prdata = {{(APB_DW-CODE_W){1'b0}}, cfg_reg.cancel_code};
            REG_BYE:    prdata = {{(APB_DW-CODE_W){1'b0}}, cfg_reg.bye_code};
            default:    prdata = '0;
        endcase
    end

    sct_front u_front (
        .cfg       (cfg_reg),
        .msg_in    (msg_in),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    sct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    sct_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .entry   (pop_data),
        .empty   (empty),
        .pop     (pop),
        .res_out (res_out)
    );

endmodule

/* hdl/sct_front.sv */
// sct_front: accepts message beats and classifies the code against the
// configured methods and the fixed response ranges. Depends on sct_pkg, sct_ifs.
module sct_front import sct_pkg::*;
(
    input  cfg_t          cfg,
    sct_msg_if.sink       msg_in,
    input  logic          full,
    output logic          push,
    output queue_entry_t  push_data
);

    assign msg_in.ready = !full;
    assign push         = msg_in.valid && !full;

    always_comb
    begin
        push_data.new_call      = msg_in.new_call;
        push_data.seq_number    = msg_in.seq_number;
        push_data.cls.invite    = msg_in.msg_code == {3'b000, cfg.invite_code};
        push_data.cls.ack       = msg_in.msg_code == {3'b000, cfg.ack_code};
        push_data.cls.cancel    = msg_in.msg_code == {3'b000, cfg.cancel_code};
        push_data.cls.bye       = msg_in.msg_code == {3'b000, cfg.bye_code};
        push_data.cls.busy      = (msg_in.msg_code == RSP_TEMP_UNAVAIL) ||
                                  (msg_in.msg_code == RSP_BUSY_HERE) ||
                                  (msg_in.msg_code == RSP_DECLINE_ALL);
        push_data.cls.above_400 = msg_in.msg_code > RSP_CLIENT_ERR_BASE;
        push_data.cls.above_300 = msg_in.msg_code > RSP_REDIRECT_BASE;
    end

endmodule

/* hdl/sct_queue.sv */
// sct_queue: short register queue of classified messages between the
// front and back parts. Depends on sct_pkg.
module sct_queue import sct_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  queue_entry_t  push_data,
    output logic          full,
    input  logic          pop,
    output queue_entry_t  pop_data,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_entry_t     entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");
    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a beat");
`endif

endmodule

/* hdl/sct_back.sv */
// sct_back: applies classified messages to the dialog state and holds the
// result beat in an output register. Depends on sct_pkg, sct_ifs.
module sct_back import sct_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_entry_t  entry,
    input  logic          empty,
    output logic          pop,
    sct_res_if.source     res_out
);

    logic               tracked_reg, tracked_next;
    logic [STATE_W-1:0] state_reg, state_next, state_base;
    logic [SEQ_W-1:0]   invite_seq_reg, invite_seq_next, seq_base;
    logic               same_seq;
    logic               started_next, ended_next;

    logic               res_valid_reg;
    logic [STATE_W-1:0] res_state_reg;
    logic               res_tracked_reg;
    logic               res_started_reg;
    logic               res_ended_reg;

    assign pop = !empty && (!res_valid_reg || res_out.ready);

    always_comb
    begin
        tracked_next = tracked_reg;
        state_base   = state_reg;
        seq_base     = invite_seq_reg;
        // a new call drops everything held for the previous one
        if (entry.new_call)
        begin
            tracked_next = entry.cls.invite;
            state_base   = ST_NONE;
            seq_base     = '0;
        end
        state_next      = state_base;
        invite_seq_next = seq_base;
        started_next    = 1'b0;
        ended_next      = 1'b0;
        same_seq        = entry.seq_number == seq_base;
        if (tracked_next)
        begin
            unique case (state_base)
                ST_SETUP:
                begin
                    priority if (entry.cls.ack && same_seq)
                    begin
                        state_next   = ST_INCALL;
                        started_next = 1'b1;
                    end
                    else if (entry.cls.cancel)
                    begin
                        state_next = ST_CANCELLED;
                    end
                    else if (entry.cls.busy)
                    begin
                        state_next = ST_BUSY;
                    end
                    else if (entry.cls.above_400 && same_seq)
                    begin
                        state_next = ST_REJECTED;
                    end
                    else if (entry.cls.above_300)
                    begin
                        state_next = ST_DIVERTED;
                    end
                    else
                    begin
                        state_next = ST_SETUP;
                    end
                end
                ST_INCALL:
                begin
                    if (entry.cls.bye)
                    begin
                        state_next = ST_COMPLETED;
                        ended_next = 1'b1;
                    end
                end
                default:
                begin
                    // none or a final state: an INVITE opens setup
                    if (entry.cls.invite)
                    begin
                        state_next      = ST_SETUP;
                        invite_seq_next = entry.seq_number;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracked_reg    <= 1'b0;
            state_reg      <= ST_NONE;
            invite_seq_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                tracked_reg    <= tracked_next;
                state_reg      <= state_next;
                invite_seq_reg <= invite_seq_next;
                res_valid_reg  <= 1'b1;
            end
            else if (res_out.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_state_reg   <= state_next;
            res_tracked_reg <= tracked_next;
            res_started_reg <= started_next;
            res_ended_reg   <= ended_next;
        end
    end

    assign res_out.valid        = res_valid_reg;
    assign res_out.call_phase   = res_state_reg;
    assign res_out.tracked      = res_tracked_reg;
    assign res_out.call_started = res_started_reg;
    assign res_out.call_ended   = res_ended_reg;

`ifndef SYNTHESIS
    a_untracked_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !tracked_reg |-> state_reg == ST_NONE)
        else $error("state moved on an untracked call");
    a_start_from_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && started_next) |-> (state_reg == ST_SETUP && !entry.new_call))
        else $error("call started outside setup");
    a_non_invite_open: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && entry.new_call && !entry.cls.invite) |=>
            (!tracked_reg && state_reg == ST_NONE))
        else $error("call opened without INVITE is tracked");
    a_end_from_incall: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && ended_next) |=> ($past(state_reg) == ST_INCALL &&
            state_reg == ST_COMPLETED))
        else $error("call ended outside in-call");
`endif

endmodule
